[sv/fgtc_pkg.sv]
// Shared types and constants of the flow graph termination check.
package fgtc_pkg;

  localparam int KindW    = 2;
  localparam int TargetW  = 11;
  localparam int VerdictW = 2;
  localparam int EdgeW    = 2;
  localparam int MarkW    = 2;

  localparam logic [KindW-1:0] KindAdvance = 2'd0;
  localparam logic [KindW-1:0] KindJump    = 2'd1;
  localparam logic [KindW-1:0] KindCond    = 2'd2;

  localparam logic [VerdictW-1:0] VerdictNever     = 2'd0;
  localparam logic [VerdictW-1:0] VerdictSometimes = 2'd1;
  localparam logic [VerdictW-1:0] VerdictAlways    = 2'd2;

  // mark bit 1: visited, bit 0: on stack
  localparam logic [MarkW-1:0] MarkClear   = 2'b00;
  localparam logic [MarkW-1:0] MarkOnStack = 2'b11;
  localparam logic [MarkW-1:0] MarkDone    = 2'b10;

  typedef enum logic [2:0] {
    StLoad,
    StStart,
    StFetch,
    StEdge,
    StCheck,
    StRestore,
    StDone
  } state_e;

endpackage

[sv/flow_graph_termination_check_core.sv]
// Top level: program loader and depth-first termination walk.
//
// Input channel (in_valid_i/in_ready_o) takes one instruction word per
// cycle while loading: kind_i, target_i and last_i. The word with last_i set
// closes the program and starts the walk from instruction 0. Words past
// MAX_INSTR are dropped; the walk then runs over MAX_INSTR instructions.
// Output channel (out_valid_o/out_ready_i) gives one verdict word per
// program: 0 never ends, 1 sometimes ends, 2 always ends.
// The walk runs in one program RAM, one mark RAM and one stack RAM, each
// with a registered read: every node takes a fetch and a closing step,
// every edge an edge step and a mark check, an edge to the end node the
// edge step alone, and each return to a parent a restore and a refetch.
// Marks of each entry are cleared as the entry is loaded, so no clearing
// pass is needed after reset or between programs.
// Reset clears all control state; RAM contents are left undefined.
// While a verdict waits for out_ready_i the next program is already
// accepted; a second verdict waits in the walk until the first is taken.
module flow_graph_termination_check_core #(
  parameter int MAX_INSTR = 1024
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [fgtc_pkg::KindW-1:0]       kind_i,
  input  logic [fgtc_pkg::TargetW-1:0]     target_i,
  input  logic                             last_i,
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [fgtc_pkg::VerdictW-1:0]    verdict_o
);

  import fgtc_pkg::*;

  localparam int AW = $clog2(MAX_INSTR);
  localparam int CW = $clog2(MAX_INSTR + 1);
  localparam int XW = (CW > TargetW) ? CW : TargetW;
  localparam int SW = AW + EdgeW;
  localparam int PW = KindW + TargetW;

  state_e               state_q, state_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [CW-1:0]        n_q, n_d;
  logic [CW-1:0]        depth_q, depth_d;
  logic [AW-1:0]        top_node_q, top_node_d;
  logic [EdgeW-1:0]     top_edge_q, top_edge_d;
  logic [AW-1:0]        w_q, w_d;
  logic                 end_q, end_d;
  logic                 cyc_q, cyc_d;
  logic                 out_valid_q, out_valid_d;
  logic [VerdictW-1:0]  verdict_q, verdict_d;

  // RAM ports
  logic                 prog_we, prog_re;
  logic [AW-1:0]        prog_waddr;
  logic [PW-1:0]        prog_wdata, prog_rdata;
  logic                 mark_we, mark_re;
  logic [AW-1:0]        mark_waddr, mark_raddr;
  logic [MarkW-1:0]     mark_wdata, mark_rdata;
  logic                 stk_we, stk_re;
  logic [AW-1:0]        stk_waddr, stk_raddr;
  logic [SW-1:0]        stk_wdata, stk_rdata;

  // edge evaluation
  logic [KindW-1:0]     rd_kind;
  logic [TargetW-1:0]   rd_tgt;
  logic [XW-1:0]        tgt_x, n_x, tgt_sat, next_x, w_x;
  logic                 edges_done;
  logic                 full;
  logic [CW-1:0]        depth_m1, depth_m2;

  fgtc_ram #(.Depth(MAX_INSTR), .Width(PW)) u_prog_ram (
    .clk_i   (clk_i),
    .we_i    (prog_we),
    .waddr_i (prog_waddr),
    .wdata_i (prog_wdata),
    .re_i    (prog_re),
    .raddr_i (top_node_q),
    .rdata_o (prog_rdata)
  );

  fgtc_ram #(.Depth(MAX_INSTR), .Width(MarkW)) u_mark_ram (
    .clk_i   (clk_i),
    .we_i    (mark_we),
    .waddr_i (mark_waddr),
    .wdata_i (mark_wdata),
    .re_i    (mark_re),
    .raddr_i (mark_raddr),
    .rdata_o (mark_rdata)
  );

  fgtc_ram #(.Depth(MAX_INSTR), .Width(SW)) u_stack_ram (
    .clk_i   (clk_i),
    .we_i    (stk_we),
    .waddr_i (stk_waddr),
    .wdata_i (stk_wdata),
    .re_i    (stk_re),
    .raddr_i (stk_raddr),
    .rdata_o (stk_rdata)
  );

  assign rd_kind  = prog_rdata[PW-1:TargetW];
  assign rd_tgt   = prog_rdata[TargetW-1:0];
  assign tgt_x    = XW'(rd_tgt);
  assign n_x      = XW'(n_q);
  assign tgt_sat  = (tgt_x > n_x) ? n_x : tgt_x;
  assign next_x   = XW'(top_node_q) + XW'(1);
  assign w_x      = ((rd_kind == KindAdvance) || (top_edge_q != '0)) ? next_x : tgt_sat;
  assign edges_done = (rd_kind >= KindCond) ? (top_edge_q >= EdgeW'(2))
                                            : (top_edge_q >= EdgeW'(1));
  assign full     = (cnt_q >= CW'(MAX_INSTR));
  assign depth_m1 = depth_q - CW'(1);
  assign depth_m2 = depth_q - CW'(2);

  assign prog_wdata = {kind_i, target_i};
  assign prog_waddr = cnt_q[AW-1:0];
  assign stk_wdata  = {top_node_q, top_edge_q};
  assign stk_waddr  = depth_m1[AW-1:0];
  assign stk_raddr  = depth_m2[AW-1:0];
  assign mark_raddr = w_x[AW-1:0];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StLoad;
      cnt_q       <= '0;
      n_q         <= '0;
      depth_q     <= '0;
      top_node_q  <= '0;
      top_edge_q  <= '0;
      w_q         <= '0;
      end_q       <= 1'b0;
      cyc_q       <= 1'b0;
      out_valid_q <= 1'b0;
      verdict_q   <= VerdictNever;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      n_q         <= n_d;
      depth_q     <= depth_d;
      top_node_q  <= top_node_d;
      top_edge_q  <= top_edge_d;
      w_q         <= w_d;
      end_q       <= end_d;
      cyc_q       <= cyc_d;
      out_valid_q <= out_valid_d;
      verdict_q   <= verdict_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    n_d         = n_q;
    depth_d     = depth_q;
    top_node_d  = top_node_q;
    top_edge_d  = top_edge_q;
    w_d         = w_q;
    end_d       = end_q;
    cyc_d       = cyc_q;
    out_valid_d = out_valid_q & ~out_ready_i;
    verdict_d   = verdict_q;
    in_ready_o  = 1'b0;
    prog_we     = 1'b0;
    prog_re     = 1'b0;
    mark_we     = 1'b0;
    mark_re     = 1'b0;
    mark_waddr  = top_node_q;
    mark_wdata  = MarkClear;
    stk_we      = 1'b0;
    stk_re      = 1'b0;

    unique case (state_q)
      StLoad: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          if (!full) begin
            prog_we    = 1'b1;
            mark_we    = 1'b1;
            mark_waddr = cnt_q[AW-1:0];
            mark_wdata = MarkClear;
            cnt_d      = cnt_q + CW'(1);
          end
          if (last_i) begin
            n_d     = full ? cnt_q : cnt_q + CW'(1);
            cnt_d   = '0;
            state_d = StStart;
          end
        end
      end
      StStart: begin
        mark_we    = 1'b1;
        mark_waddr = '0;
        mark_wdata = MarkOnStack;
        top_node_d = '0;
        top_edge_d = '0;
        depth_d    = CW'(1);
        end_d      = 1'b0;
        cyc_d      = 1'b0;
        state_d    = StFetch;
      end
      StFetch: begin
        prog_re = 1'b1;
        state_d = StEdge;
      end
      StEdge: begin
        if (edges_done) begin
          mark_we    = 1'b1;
          mark_waddr = top_node_q;
          mark_wdata = MarkDone;
          depth_d    = depth_m1;
          if (depth_q == CW'(1)) begin
            state_d = StDone;
          end else begin
            stk_re  = 1'b1;
            state_d = StRestore;
          end
        end else begin
          top_edge_d = top_edge_q + EdgeW'(1);
          if (w_x >= n_x) begin
            end_d = 1'b1;
          end else begin
            mark_re = 1'b1;
            w_d     = w_x[AW-1:0];
            state_d = StCheck;
          end
        end
      end
      StCheck: begin
        if (mark_rdata[0]) begin
          cyc_d   = 1'b1;
          state_d = StEdge;
        end else if (!mark_rdata[1]) begin
          mark_we    = 1'b1;
          mark_waddr = w_q;
          mark_wdata = MarkOnStack;
          stk_we     = 1'b1;
          top_node_d = w_q;
          top_edge_d = '0;
          depth_d    = depth_q + CW'(1);
          state_d    = StFetch;
        end else begin
          state_d = StEdge;
        end
      end
      StRestore: begin
        top_node_d = stk_rdata[SW-1:EdgeW];
        top_edge_d = stk_rdata[EdgeW-1:0];
        state_d    = StFetch;
      end
      StDone: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          if (!end_q) begin
            verdict_d = VerdictNever;
          end else if (cyc_q) begin
            verdict_d = VerdictSometimes;
          end else begin
            verdict_d = VerdictAlways;
          end
          state_d = StLoad;
        end
      end
      default: state_d = StLoad;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign verdict_o   = verdict_q;

  a_check_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StCheck) |-> (CW'(w_q) < n_q))
    else $error("checked node outside program");

  a_depth_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StFetch) || (state_q == StEdge) || (state_q == StCheck))
      |-> ((depth_q != '0) && (depth_q <= n_q)))
    else $error("walk depth out of range");

  a_done_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StDone) |-> (depth_q == '0))
    else $error("walk ended with stack not empty");

  a_push_marks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((state_q == StCheck) && !mark_rdata[1]) |=> (state_q == StFetch))
    else $error("unvisited node not pushed");

endmodule

[sv/fgtc_ram.sv]
// Single-port-write, single-port-read synchronous RAM with registered read data.
module fgtc_ram #(
  parameter int Depth = 1024,
  parameter int Width = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
